@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and control types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int TAB_STOP   = 8;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_N     = (ROWS - 1) * COLUMNS;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W  = $clog2(CELL_COUNT + 1);

	// fixed field widths
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int CELL_W  = 16;
	localparam int LOCF_W  = 11;
	localparam int LOC_W   = (ADDR_W > LOCF_W) ? ADDR_W : LOCF_W;
	localparam int RES_W   = CELL_W + LOCF_W + 1;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_ATTR = 1'b0;   // register select, paddr[2]
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// cell values and character codes
	localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0720;
	localparam logic [CELL_W-1:0] SCROLL_BLANK = 16'h0F20;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic take;          // latch a new request
		logic exec_put;      // write the cell and move the cursor
		logic clr_cursor;
		logic fill_we;       // sweep write of a blank
		logic fill_init;     // blank is the power-on cell
		logic scroll_step;   // one step of the row copy
		logic cnt_clr;
		logic cnt_inc;
		logic rd_issue;
		logic rd_capture;
		logic set_scrolled;
		logic load_out;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CMD_W-1:0] req_cmd;
		logic need_scroll;
		logic fill_last;
		logic scroll_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/text_console_char_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: 80x25 cell store, cursor, put/read/clear requests.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives exactly one result. After
// reset the block runs a clearing pass over the 2000-cell store, one cell a
// cycle, and takes no request until the pass ends (the APB register is
// writable throughout). A read goes through the registered store read; a
// clear sweeps the store one cell a cycle; a put that runs past the last row
// copies the store up one row through its single read and single write port.
// A finished result sits in the output register while the next request is
// taken.
module text_console_char_writer (
	input  logic                             clk,
	input  logic                             arst_n,
	// request in
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tcw_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // char_code[7:0], read_index[18:8]
	input  logic [tcw_pkg::CMD_W-1:0]        s_axis_tuser,  // command[1:0]
	// result out
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tcw_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // cell_data[15:0], cursor_location[26:16], scrolled[27]
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tcw_pkg::APB_AW-1:0]       paddr,
	input  logic [tcw_pkg::APB_DW-1:0]       pwdata,
	output logic [tcw_pkg::APB_DW-1:0]       prdata,
	output logic                             pready
);

	logic [7:0]                attr;
	tcw_pkg::dp_cmd_t          cmd;
	tcw_pkg::dp_stat_t         stat;
	logic [tcw_pkg::RES_W-1:0] res_data;

	tcw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.attr    (attr)
	);

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcw_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_cmd   (s_axis_tuser),
		.req_char  (s_axis_tdata[7:0]),
		.req_idx   (s_axis_tdata[18:8]),
		.attr      (attr),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res_data)
	);

	assign m_axis_tdata = {{(tcw_pkg::M_TDATA_W - tcw_pkg::RES_W){1'b0}}, res_data};

endmodule

@@ rtl/tcw_regs.sv @@
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration register file: text attribute, APB access.
// ----------------------------------------------------------------------------
module tcw_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tcw_pkg::APB_AW-1:0] paddr,
	input  logic [tcw_pkg::APB_DW-1:0] pwdata,
	output logic [tcw_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [7:0]                 attr
);

	logic [7:0] attr_q;
	logic       sel_attr;

	assign pready   = 1'b1;
	assign sel_attr = (paddr[2] == tcw_pkg::REG_ATTR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && sel_attr) begin
			attr_q <= pwdata[7:0];
		end
	end

	assign prdata = sel_attr ? {{(tcw_pkg::APB_DW - 8){1'b0}}, attr_q} : '0;
	assign attr   = attr_q;

endmodule

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: power-on clearing pass, request decode, sweeps and response.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tcw_pkg::dp_stat_t stat,
	output tcw_pkg::dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_INIT   = 7'b0000001,
		S_IDLE   = 7'b0000010,
		S_EXEC   = 7'b0000100,
		S_READ   = 7'b0001000,
		S_SCROLL = 7'b0010000,
		S_FILL   = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.fill_we   = 1'b1;
				cmd.fill_init = 1'b1;
				cmd.cnt_inc   = 1'b1;
				if (stat.fill_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.req_cmd)
					tcw_pkg::CMD_PUT: begin
						cmd.exec_put = 1'b1;
						if (stat.need_scroll) begin
							cmd.set_scrolled = 1'b1;
							cmd.cnt_clr      = 1'b1;
							state_d          = S_SCROLL;
						end else begin
							cmd.load_out = 1'b1;
							state_d      = stat.out_free ? S_IDLE : S_RESP;
						end
					end
					tcw_pkg::CMD_READ: begin
						cmd.rd_issue = 1'b1;
						state_d      = S_READ;
					end
					tcw_pkg::CMD_CLEAR: begin
						cmd.clr_cursor = 1'b1;
						cmd.cnt_clr    = 1'b1;
						state_d        = S_FILL;
					end
					default: begin
						cmd.load_out = 1'b1;
						state_d      = stat.out_free ? S_IDLE : S_RESP;
					end
				endcase
			end
			S_READ: begin
				cmd.rd_capture = 1'b1;
				state_d        = S_RESP;
			end
			S_SCROLL: begin
				cmd.scroll_step = 1'b1;
				cmd.cnt_inc     = 1'b1;
				if (stat.scroll_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_FILL: begin
				cmd.fill_we = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (stat.fill_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_RESP;
				end
			end
			S_RESP: begin
				cmd.load_out = 1'b1;
				if (stat.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

endmodule

@@ rtl/tcw_dpath.sv @@
// ----------------------------------------------------------------------------
// tcw_dpath
// Cell store, cursor, sweep counter, request latch and result register.
// ----------------------------------------------------------------------------
module tcw_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tcw_pkg::CMD_W-1:0]     req_cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]    req_char,
	input  logic [tcw_pkg::IDX_W-1:0]     req_idx,
	input  logic [7:0]                    attr,
	input  tcw_pkg::dp_cmd_t              cmd,
	output tcw_pkg::dp_stat_t             stat,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::RES_W-1:0]     out_data
);

	localparam int COL_W  = tcw_pkg::COL_W;
	localparam int ROW_W  = tcw_pkg::ROW_W;
	localparam int ADDR_W = tcw_pkg::ADDR_W;
	localparam int CNT_W  = tcw_pkg::CNT_W;
	localparam int LOC_W  = tcw_pkg::LOC_W;

	logic [tcw_pkg::CMD_W-1:0]  req_cmd_q;
	logic [tcw_pkg::CHAR_W-1:0] req_char_q;
	logic [tcw_pkg::IDX_W-1:0]  req_idx_q;
	logic [COL_W-1:0]           col_q, col_d, col_fin, put_col;
	logic [ROW_W-1:0]           row_q, row_d, row_fin;
	logic [COL_W:0]             col_n;
	logic [ROW_W:0]             row_n;
	logic                       need_scroll;
	logic                       put_we;
	logic [tcw_pkg::CELL_W-1:0] put_data, blank;
	logic [ADDR_W-1:0]          put_addr;
	logic [CNT_W-1:0]           cnt_q, cnt_dec, cnt_src;
	logic [LOC_W-1:0]           loc_full;
	logic                       rd_in_range;

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
	logic                       mem_we, mem_re;
	logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata, rdata_q;

	logic [tcw_pkg::CELL_W-1:0] cell_q;
	logic                       scr_q;
	logic                       out_valid_q;
	logic [tcw_pkg::RES_W-1:0]  out_data_q;
	logic                       out_free;

	assign blank = {attr, tcw_pkg::CH_SPACE};

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_cmd_q  <= req_cmd;
			req_char_q <= req_char;
			req_idx_q  <= req_idx;
		end
	end

	// character interpretation; column carries one spare bit for the wrap test
	always_comb begin
		col_n    = {1'b0, col_q};
		row_n    = {1'b0, row_q};
		put_we   = 1'b0;
		put_col  = col_q;
		put_data = blank;
		case (req_char_q)
			tcw_pkg::CH_BS: begin
				if (col_q != '0) begin
					col_n   = col_n - 1'b1;
					put_we  = 1'b1;
					put_col = col_q - 1'b1;
				end
			end
			tcw_pkg::CH_TAB: begin
				put_we = 1'b1;
				col_n  = (COL_W + 1)'((int'(col_q) / tcw_pkg::TAB_STOP + 1)
					* tcw_pkg::TAB_STOP);
			end
			tcw_pkg::CH_CR: begin
				col_n = '0;
			end
			tcw_pkg::CH_LF: begin
				col_n = '0;
				row_n = row_n + 1'b1;
			end
			default: begin
				if (req_char_q >= tcw_pkg::CH_SPACE && req_char_q <= tcw_pkg::CH_TILDE) begin
					put_we   = 1'b1;
					put_data = {attr, req_char_q};
					col_n    = col_n + 1'b1;
				end
			end
		endcase
		if (col_n >= (COL_W + 1)'(tcw_pkg::COLUMNS)) begin
			col_n = '0;
			row_n = row_n + 1'b1;
		end
	end

	assign need_scroll = (row_n >= (ROW_W + 1)'(tcw_pkg::ROWS));
	assign row_fin     = need_scroll ? ROW_W'(tcw_pkg::ROWS - 1) : row_n[ROW_W-1:0];
	assign col_fin     = col_n[COL_W-1:0];
	assign put_addr    = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(tcw_pkg::COLUMNS))
		+ ADDR_W'(put_col);

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cmd.clr_cursor) begin
			col_d = '0;
			row_d = '0;
		end else if (cmd.exec_put) begin
			col_d = col_fin;
			row_d = row_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// sweep counter: fill writes cnt, the row copy reads cnt+COLUMNS and writes cnt-1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign cnt_dec     = cnt_q - 1'b1;
	assign cnt_src     = cnt_q + CNT_W'(tcw_pkg::COLUMNS);
	assign rd_in_range = (LOC_W'(req_idx_q) < LOC_W'(tcw_pkg::CELL_COUNT));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = put_addr;
		mem_wdata = put_data;
		if (cmd.exec_put && put_we) begin
			mem_we = 1'b1;
		end else if (cmd.fill_we) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q[ADDR_W-1:0];
			mem_wdata = cmd.fill_init ? tcw_pkg::RESET_CELL : blank;
		end else if (cmd.scroll_step && cnt_q != '0) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_dec[ADDR_W-1:0];
			mem_wdata = (cnt_dec < CNT_W'(tcw_pkg::COPY_N)) ? rdata_q : tcw_pkg::SCROLL_BLANK;
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cnt_src[ADDR_W-1:0];
		if (cmd.rd_issue) begin
			mem_re    = rd_in_range;
			mem_raddr = ADDR_W'(req_idx_q);
		end else if (cmd.scroll_step && cnt_q < CNT_W'(tcw_pkg::COPY_N)) begin
			mem_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cell_q <= '0;
			scr_q  <= 1'b0;
		end else begin
			if (cmd.rd_capture) begin
				cell_q <= rd_in_range ? rdata_q : '0;
			end
			if (cmd.set_scrolled) begin
				scr_q <= 1'b1;
			end
		end
	end

	// cursor after this step goes straight to the result
	assign loc_full = LOC_W'(LOC_W'(row_d) * LOC_W'(tcw_pkg::COLUMNS)) + LOC_W'(col_d);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out && out_free) begin
			out_data_q <= {scr_q, loc_full[tcw_pkg::LOCF_W-1:0], cell_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.req_cmd     = req_cmd_q;
	assign stat.need_scroll = need_scroll;
	assign stat.fill_last   = (cnt_q == CNT_W'(tcw_pkg::CELL_COUNT - 1));
	assign stat.scroll_last = (cnt_q == CNT_W'(tcw_pkg::CELL_COUNT));
	assign stat.out_free    = out_free;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q < COL_W'(tcw_pkg::COLUMNS))
		else $error("cursor column beyond last column");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q < ROW_W'(tcw_pkg::ROWS))
		else $error("cursor row beyond last row");

	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CNT_W'(mem_waddr) < CNT_W'(tcw_pkg::CELL_COUNT)))
		else $error("cell store write outside screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_scrolled |=> row_q == ROW_W'(tcw_pkg::ROWS - 1))
		else $error("scroll did not leave cursor on last row");

endmodule

@@ test/text_console_char_writer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the text console character writer.
// ----------------------------------------------------------------------------
// A short table of directed requests covers reset contents, the edges of the
// printable range, ignored characters, backspace at column zero, tab, CR, LF,
// the unused command, clear and out-of-range reads. Six random phases follow,
// each with its own text attribute (written over APB and read back while the
// block is idle) and short or long lines by turns, so that wrapping, tab-wrap
// and scrolling are reached. Shadow screen and cursor predict each result the
// table leaves open; every result is checked field by field on the stream.
// ----------------------------------------------------------------------------
module text_console_char_writer_tb;

	localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int N_DIRECTED      = 24;
	localparam int PHASES          = 6;
	localparam int REQS_PER_PHASE  = 313;
	localparam int WATCHDOG_LIMIT  = 10000;
	localparam int MAX_REPORTED    = 10;

	localparam logic [tcw_pkg::CMD_W-1:0]  C_PUT   = tcw_pkg::CMD_PUT;
	localparam logic [tcw_pkg::CMD_W-1:0]  C_READ  = tcw_pkg::CMD_READ;
	localparam logic [tcw_pkg::CMD_W-1:0]  C_CLEAR = tcw_pkg::CMD_CLEAR;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_BS    = tcw_pkg::CH_BS;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_TAB   = tcw_pkg::CH_TAB;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_CR    = tcw_pkg::CH_CR;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_LF    = tcw_pkg::CH_LF;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_SPACE = tcw_pkg::CH_SPACE;
	localparam logic [tcw_pkg::CHAR_W-1:0] C_TILDE = tcw_pkg::CH_TILDE;

	typedef struct packed {
		logic [tcw_pkg::CELL_W-1:0] cell_data;
		logic [tcw_pkg::LOCF_W-1:0] loc;
		logic                       scrolled;
	} console_result_t;

	typedef struct packed {
		logic [tcw_pkg::CMD_W-1:0]  cmd;
		logic [tcw_pkg::CHAR_W-1:0] ch;
		logic [tcw_pkg::IDX_W-1:0]  idx;
		logic                       typed;    // want holds a hand-written result
		console_result_t            want;
	} request_row_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [tcw_pkg::CMD_W-1:0]     s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [tcw_pkg::APB_AW-1:0]    paddr = '0;
	logic [tcw_pkg::APB_DW-1:0]    pwdata = '0;
	logic [tcw_pkg::APB_DW-1:0]    prdata;
	logic                          pready;

	text_console_char_writer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// shadow of the screen, cursor and attribute register
	logic [tcw_pkg::CELL_W-1:0] screen_shadow [tcw_pkg::CELL_COUNT];
	int                         cur_col;
	int                         cur_row;
	logic [7:0]                 attr_shadow;

	console_result_t   pending_results [$];
	request_row_t      directed_rows [N_DIRECTED];
	int                mismatch_count = 0;
	int                idle_pct = 0;
	int                idle_cycles = 0;
	int                ready_stall = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic console_result_t apply_console_request(
			input logic [tcw_pkg::CMD_W-1:0] cmd,
			input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::IDX_W-1:0] idx);
		console_result_t            res;
		logic [tcw_pkg::CELL_W-1:0] blank;
		int                         i;
		res = '0;
		blank = {attr_shadow, tcw_pkg::CH_SPACE};
		case (cmd)
			C_PUT: begin
				if (ch == tcw_pkg::CH_BS) begin
					if (cur_col != 0) begin
						cur_col--;
						screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = blank;
					end
				end else if (ch == tcw_pkg::CH_TAB) begin
					screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = blank;
					cur_col = (cur_col / tcw_pkg::TAB_STOP + 1) * tcw_pkg::TAB_STOP;
				end else if (ch == tcw_pkg::CH_CR) begin
					cur_col = 0;
				end else if (ch == tcw_pkg::CH_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (ch >= tcw_pkg::CH_SPACE && ch <= tcw_pkg::CH_TILDE) begin
					screen_shadow[cur_row * tcw_pkg::COLUMNS + cur_col] = {attr_shadow, ch};
					cur_col++;
				end
				if (cur_col >= tcw_pkg::COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= tcw_pkg::ROWS) begin
					for (i = 0; i < tcw_pkg::COPY_N; i++)
						screen_shadow[i] = screen_shadow[i + tcw_pkg::COLUMNS];
					for (i = tcw_pkg::COPY_N; i < tcw_pkg::CELL_COUNT; i++)
						screen_shadow[i] = tcw_pkg::SCROLL_BLANK;
					cur_row = tcw_pkg::ROWS - 1;
					res.scrolled = 1'b1;
				end
			end
			C_READ: begin
				if (idx < tcw_pkg::CELL_COUNT)
					res.cell_data = screen_shadow[idx];
			end
			C_CLEAR: begin
				for (i = 0; i < tcw_pkg::CELL_COUNT; i++)
					screen_shadow[i] = blank;
				cur_col = 0;
				cur_row = 0;
			end
			default: ;
		endcase
		res.loc = tcw_pkg::LOCF_W'(cur_row * tcw_pkg::COLUMNS + cur_col);
		return res;
	endfunction

	task automatic note_mismatch(input string what, input logic [tcw_pkg::APB_DW-1:0] want,
			input logic [tcw_pkg::APB_DW-1:0] got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// called at a clock edge; returns at the edge where the request is taken
	task automatic send_request(input logic [tcw_pkg::CMD_W-1:0] cmd,
			input logic [tcw_pkg::CHAR_W-1:0] ch, input logic [tcw_pkg::IDX_W-1:0] idx,
			input logic typed, input console_result_t want);
		console_result_t predicted;
		if (idle_pct != 0 && int'($urandom_range(0, 99)) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		predicted = apply_console_request(cmd, ch, idx);
		pending_results.push_back(typed ? want : predicted);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(tcw_pkg::S_TDATA_W - tcw_pkg::IDX_W - tcw_pkg::CHAR_W){1'b0}},
			idx, ch};
		s_axis_tuser <= cmd;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// write then read back; psel is held across both transfers
	task automatic write_text_attribute(input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {tcw_pkg::REG_ATTR, 2'b00};
		pwdata <= tcw_pkg::APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		attr_shadow = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== tcw_pkg::APB_DW'(value))
			note_mismatch("text_attribute readback", tcw_pkg::APB_DW'(value), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		console_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result", '0, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[15:0] !== want.cell_data)
					note_mismatch("cell_data", tcw_pkg::APB_DW'(want.cell_data),
						tcw_pkg::APB_DW'(m_axis_tdata[15:0]));
				if (m_axis_tdata[26:16] !== want.loc)
					note_mismatch("cursor_location", tcw_pkg::APB_DW'(want.loc),
						tcw_pkg::APB_DW'(m_axis_tdata[26:16]));
				if (m_axis_tdata[27] !== want.scrolled)
					note_mismatch("scrolled", tcw_pkg::APB_DW'(want.scrolled),
						tcw_pkg::APB_DW'(m_axis_tdata[27]));
			end
		end
	end

	// result-side back-pressure in bursts
	always @(posedge clk) begin
		if (ready_stall == 0 && idle_pct != 0 && int'($urandom_range(0, 99)) < idle_pct / 2)
			ready_stall = int'($urandom_range(1, 6));
		if (ready_stall > 0) begin
			m_axis_tready <= 1'b0;
			ready_stall--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int                         p;
		int                         k;
		int                         sel;
		int                         near;
		int                         nl_pct;
		logic [tcw_pkg::CMD_W-1:0]  cmd;
		logic [tcw_pkg::CHAR_W-1:0] ch;
		logic [tcw_pkg::IDX_W-1:0]  idx;

		for (k = 0; k < tcw_pkg::CELL_COUNT; k++)
			screen_shadow[k] = tcw_pkg::RESET_CELL;
		cur_col = 0;
		cur_row = 0;
		attr_shadow = tcw_pkg::ATTR_RESET;

		directed_rows = '{
			'{C_READ,     8'h00, 11'd0,    1'b1, '{16'h0720, 11'd0, 1'b0}},
			'{C_READ,     8'h00, 11'd1999, 1'b1, '{16'h0720, 11'd0, 1'b0}},
			'{C_READ,     8'hFF, 11'd2047, 1'b1, '{16'h0000, 11'd0, 1'b0}},
			'{C_PUT,      C_BS, 11'd0,     1'b1, '{16'h0000, 11'd0, 1'b0}},
			'{C_PUT,      8'h41, 11'd0,    1'b1, '{16'h0000, 11'd1, 1'b0}},
			'{C_PUT,      C_SPACE, 11'd0,  1'b1, '{16'h0000, 11'd2, 1'b0}},
			'{C_PUT,      C_TILDE, 11'd0,  1'b1, '{16'h0000, 11'd3, 1'b0}},
			'{C_PUT,      8'h7F, 11'd0,    1'b1, '{16'h0000, 11'd3, 1'b0}},
			'{C_PUT,      8'hFF, 11'd2047, 1'b1, '{16'h0000, 11'd3, 1'b0}},
			'{C_PUT,      8'h00, 11'd0,    1'b1, '{16'h0000, 11'd3, 1'b0}},
			'{C_PUT,      8'h1F, 11'd0,    1'b0, '0},
			'{C_READ,     8'h00, 11'd0,    1'b1, '{16'h0741, 11'd3, 1'b0}},
			'{C_READ,     8'h00, 11'd2,    1'b0, '0},
			'{C_PUT,      C_BS, 11'd0,     1'b1, '{16'h0000, 11'd2, 1'b0}},
			'{C_READ,     8'h00, 11'd2,    1'b0, '0},
			'{C_PUT,      C_TAB, 11'd0,    1'b0, '0},
			'{C_READ,     8'h00, 11'd2000, 1'b0, '0},
			'{C_PUT,      C_CR, 11'd0,     1'b0, '0},
			'{C_PUT,      C_LF, 11'd0,     1'b0, '0},
			'{CMD_UNUSED, 8'hFF, 11'd2047, 1'b0, '0},
			'{C_CLEAR,    8'hFF, 11'd2047, 1'b1, '{16'h0000, 11'd0, 1'b0}},
			'{C_READ,     8'h00, 11'd1999, 1'b1, '{16'h0720, 11'd0, 1'b0}},
			'{C_PUT,      8'h0B, 11'd0,    1'b0, '0},
			'{C_READ,     8'h00, 11'd80,   1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 20;
		for (k = 0; k < N_DIRECTED; k++)
			send_request(directed_rows[k].cmd, directed_rows[k].ch, directed_rows[k].idx,
				directed_rows[k].typed, directed_rows[k].want);

		for (p = 0; p < PHASES; p++) begin
			s_axis_tvalid <= 1'b0;
			while (pending_results.size() != 0) @(posedge clk);
			write_text_attribute((p == 0) ? 8'h00 : (p == 1) ? 8'hFF :
				8'($urandom_range(0, 255)));
			// even phases: short lines and frequent scrolling; odd: long lines, wrapping
			nl_pct = (p % 2 == 0) ? 10 : 1;
			idle_pct = (p == PHASES - 1) ? 0 : 15 + 10 * (p % 2);
			for (k = 0; k < REQS_PER_PHASE; k++) begin
				ch = 8'($urandom_range(0, 255));
				idx = 11'($urandom_range(0, 2047));
				sel = int'($urandom_range(0, 999));
				if (sel < 2) begin
					cmd = C_CLEAR;
				end else if (sel < 4) begin
					cmd = CMD_UNUSED;
				end else if (sel < 204) begin
					cmd = C_READ;
					sel = int'($urandom_range(0, 7));
					if (sel >= 1 && sel <= 4) begin
						idx = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
					end else if (sel > 4) begin
						near = cur_row * tcw_pkg::COLUMNS + cur_col
							- int'($urandom_range(0, tcw_pkg::COLUMNS));
						idx = 11'((near < 0) ? 0 : near);
					end
				end else begin
					cmd = C_PUT;
					sel = int'($urandom_range(0, 99));
					if (sel < nl_pct)
						ch = C_LF;
					else if (sel < nl_pct + 3)
						ch = C_CR;
					else if (sel < nl_pct + 7)
						ch = C_TAB;
					else if (sel < nl_pct + 11)
						ch = C_BS;
					else if (sel >= nl_pct + 15)
						ch = 8'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_TILDE));
				end
				send_request(cmd, ch, idx, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
